// ----- hdl/lcs_pkg.sv -----
// Shared constants, action codes, control structs and state type for the LCS length unit.
`default_nettype none

package lcs_pkg;

   // Longest string that is held; further characters are dropped and flagged.
   localparam int MAX_LEN = 256;

   // Field widths of the request and response channels.
   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int LEN_W    = 9;

   // Counts and table entries reach MAX_LEN itself; addresses stay below it.
   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

   // Action codes carried by req_action.
   localparam logic [ACTION_W-1:0] ACT_FIRST   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SECOND  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROW,
      ST_CELL,
      ST_DONE
   } state_type;

   // Controls from the sequencer to the cell datapath.
   typedef struct packed {
      logic row_init;
      logic pend;
      logic first_row;
   } cell_ctl_type;

   // Memory port controls from the sequencer.
   typedef struct packed {
      logic              t1_we;
      logic              t2_we;
      logic [ADDR_W-1:0] t_waddr;
      logic              t1_re;
      logic [ADDR_W-1:0] t1_raddr;
      logic              col_re;
      logic [ADDR_W-1:0] col_raddr;
      logic [ADDR_W-1:0] dp_waddr;
   } mem_req_type;

endpackage

`default_nettype wire

// ----- hdl/lcs_length_unit.sv -----
// Top level of the LCS length unit: two text memories, one table-row memory and the walk.
//
// Append actions (first or second string) are taken only while idle, so characters can
// be loaded on every clock while busy is low. A compute action walks the
// dynamic-programming table one entry per clock through the table-row memory; each row
// also has a step to fetch that row's character and a step to write back the row's last
// entry. busy stays high for the whole walk, and the result transfer happens at its end.
// The result is shown for exactly one cycle with rsp_strobe and cannot be held off,
// after which both strings and the overflow flag are empty again. Characters beyond
// MAX_LEN per string are dropped and reported through rsp_overflow. Action code 3 does
// nothing.
`default_nettype none

module lcs_length_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [lcs_pkg::ACTION_W-1:0] req_action,
   input  wire logic [lcs_pkg::CHAR_W-1:0]   req_char_value,
   output logic                             rsp_strobe,
   output logic      [lcs_pkg::LEN_W-1:0]    rsp_lcs_length,
   output logic                             rsp_overflow
);

   import lcs_pkg::*;

   mem_req_type      mem_req;
   cell_ctl_type     cell_ctl;
   logic [CHAR_W-1:0] first_char;
   logic [CHAR_W-1:0] second_char;
   logic [CNT_W-1:0]  up_raw;
   logic [CNT_W-1:0]  next_value;
   logic [CNT_W-1:0]  left_value;

   // Sequencer.
   lcs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_action   (req_action),
      .busy         (busy),
      .mem_req      (mem_req),
      .cell_ctl     (cell_ctl),
      .rsp_strobe   (rsp_strobe),
      .rsp_overflow (rsp_overflow)
   );

   // First string, read once per row.
   lcs_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_text (
      .clock   (clock),
      .wr_en   (mem_req.t1_we),
      .wr_addr (mem_req.t_waddr),
      .wr_data (req_char_value),
      .rd_en   (mem_req.t1_re),
      .rd_addr (mem_req.t1_raddr),
      .rd_data (first_char)
   );

   // Second string, read once per column.
   lcs_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second_text (
      .clock   (clock),
      .wr_en   (mem_req.t2_we),
      .wr_addr (mem_req.t_waddr),
      .wr_data (req_char_value),
      .rd_en   (mem_req.col_re),
      .rd_addr (mem_req.col_raddr),
      .rd_data (second_char)
   );

   // Table row: entry j of the row lives at address j - 1; entry zero is always zero.
   lcs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_dp_row (
      .clock   (clock),
      .wr_en   (cell_ctl.pend),
      .wr_addr (mem_req.dp_waddr),
      .wr_data (next_value),
      .rd_en   (mem_req.col_re),
      .rd_addr (mem_req.col_raddr),
      .rd_data (up_raw)
   );

   // Recurrence datapath.
   lcs_cell u_cell (
      .clock       (clock),
      .ctl         (cell_ctl),
      .first_char  (first_char),
      .second_char (second_char),
      .up_raw      (up_raw),
      .next_value  (next_value),
      .left_value  (left_value)
   );

   // After the last row the left register holds the final table entry.
   assign rsp_lcs_length = LEN_W'(left_value);

endmodule

`default_nettype wire

// ----- hdl/lcs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/lcs_cell.sv -----
// Cell datapath of the LCS recurrence: match, diagonal increment and left/up maximum.
`default_nettype none

module lcs_cell (
   input  wire logic                      clock,
   input  wire lcs_pkg::cell_ctl_type     ctl,
   input  wire logic [lcs_pkg::CHAR_W-1:0] first_char,
   input  wire logic [lcs_pkg::CHAR_W-1:0] second_char,
   input  wire logic [lcs_pkg::CNT_W-1:0]  up_raw,
   output logic      [lcs_pkg::CNT_W-1:0]  next_value,
   output logic      [lcs_pkg::CNT_W-1:0]  left_value
);

   import lcs_pkg::*;

   logic [CNT_W-1:0] left_ff;
   logic [CNT_W-1:0] left_in;
   logic [CNT_W-1:0] diag_ff;
   logic [CNT_W-1:0] diag_in;
   logic [CNT_W-1:0] up_value;

   // Table row zero is all zero, so the first row ignores what the row memory returns.
   assign up_value = ctl.first_row ? '0 : up_raw;

   // New entry: diagonal plus one on a match, else the larger neighbor.
   always_comb begin
      if (first_char == second_char) begin
         next_value = diag_ff + CNT_W'(1);
      end else if (left_ff > up_value) begin
         next_value = left_ff;
      end else begin
         next_value = up_value;
      end
   end

   // Left and diagonal values walk along the row with the column.
   always_comb begin
      left_in = left_ff;
      diag_in = diag_ff;
      if (ctl.row_init) begin
         left_in = '0;
         diag_in = '0;
      end else if (ctl.pend) begin
         left_in = next_value;
         diag_in = up_value;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      diag_ff <= diag_in;
   end

   assign left_value = left_ff;

endmodule

`default_nettype wire

// ----- hdl/lcs_ctrl.sv -----
// Sequencer of the LCS length unit: string loading, row and column walk, result transfer.
`default_nettype none

module lcs_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [lcs_pkg::ACTION_W-1:0] req_action,
   output logic                             busy,
   output lcs_pkg::mem_req_type             mem_req,
   output lcs_pkg::cell_ctl_type            cell_ctl,
   output logic                             rsp_strobe,
   output logic                             rsp_overflow
);

   import lcs_pkg::*;

   state_type         state_ff;
   state_type         state_in;
   logic [CNT_W-1:0]  first_count_ff;
   logic [CNT_W-1:0]  first_count_in;
   logic [CNT_W-1:0]  second_count_ff;
   logic [CNT_W-1:0]  second_count_in;
   logic              drop_ff;
   logic              drop_in;
   logic [CNT_W-1:0]  row_ff;
   logic [CNT_W-1:0]  row_in;
   logic [CNT_W-1:0]  col_ff;
   logic [CNT_W-1:0]  col_in;
   logic              pend_ff;
   logic              pend_in;
   logic [ADDR_W-1:0] pend_col_ff;
   logic [ADDR_W-1:0] pend_col_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (req_action == ACT_COMPUTE)) begin
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            state_in = (row_ff == first_count_ff) ? ST_DONE : ST_CELL;
         end
         ST_CELL: begin
            if (col_ff == second_count_ff) begin
               state_in = ST_ROW;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and counter updates.
   always_comb begin
      first_count_in     = first_count_ff;
      second_count_in    = second_count_ff;
      drop_in            = drop_ff;
      row_in             = row_ff;
      col_in             = col_ff;
      pend_in            = 1'b0;
      pend_col_in        = pend_col_ff;
      mem_req            = '0;
      mem_req.t1_raddr   = row_ff[ADDR_W-1:0];
      mem_req.col_raddr  = col_ff[ADDR_W-1:0];
      mem_req.dp_waddr   = pend_col_ff;
      cell_ctl           = '0;
      cell_ctl.pend      = pend_ff;
      cell_ctl.first_row = (row_ff == '0);
      unique case (state_ff)
         ST_IDLE: begin
            mem_req.t_waddr = (req_action == ACT_SECOND) ? second_count_ff[ADDR_W-1:0]
                                                         : first_count_ff[ADDR_W-1:0];
            if (start) begin
               unique case (req_action)
                  ACT_FIRST: begin
                     if (first_count_ff < MAX_CNT) begin
                        mem_req.t1_we  = 1'b1;
                        first_count_in = first_count_ff + CNT_W'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  ACT_SECOND: begin
                     if (second_count_ff < MAX_CNT) begin
                        mem_req.t2_we   = 1'b1;
                        second_count_in = second_count_ff + CNT_W'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  ACT_COMPUTE: begin
                     row_in            = '0;
                     cell_ctl.row_init = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROW: begin
            // Fetch the row character once; it stays on the read port for the row.
            if (row_ff != first_count_ff) begin
               mem_req.t1_re     = 1'b1;
               col_in            = '0;
               cell_ctl.row_init = 1'b1;
            end
         end
         ST_CELL: begin
            // Issue one column per cycle; the entry is written back in the following cycle.
            if (col_ff != second_count_ff) begin
               mem_req.col_re = 1'b1;
               col_in         = col_ff + CNT_W'(1);
               pend_in        = 1'b1;
               pend_col_in    = col_ff[ADDR_W-1:0];
            end else begin
               row_in = row_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            first_count_in  = '0;
            second_count_in = '0;
            drop_in         = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         drop_ff         <= 1'b0;
         pend_ff         <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         drop_ff         <= drop_in;
         pend_ff         <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      pend_col_ff <= pend_col_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = (state_ff == ST_DONE);
   assign rsp_overflow = drop_ff;

endmodule

`default_nettype wire
